// ===== hdl/pixel_source_remap_assert.svh =====
// Assertion macros shared by the pixel source remap RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef PIXEL_SOURCE_REMAP_ASSERT_SVH
`define PIXEL_SOURCE_REMAP_ASSERT_SVH
`ifndef ASSERT_OFF
// Checked property, switched off while reset is asserted.
`define PSR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked property that also applies during reset.
`define PSR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PSR_ASSERT(lbl, clk, rst_n, prop, msg)
`define PSR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== hdl/psr_pkg.sv =====
// Package for the pixel source remap block: field widths, register indices,
// remap mode codes and fixed constants. No dependencies.
`timescale 1ns / 1ps

package psr_pkg;

  localparam int COORD_W    = 11;
  localparam int JIT_W      = 2;
  localparam int INDEX_W    = 22;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_ADDR_W = 2;
  localparam int MODE_W     = 3;

  localparam int MAX_DIM_DEF = 2048;
  localparam int TILE_SIZE   = 16;
  localparam int TILE_LOG2   = 4;
  localparam int JIT_BIAS    = 2;

  localparam logic [CFG_ADDR_W-1:0] REG_REMAP_MODE   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 2'd2;

  localparam logic [MODE_W-1:0] MODE_IDENTITY    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_MIRROR_X    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FLIP_Y      = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MIRROR_FLIP = 3'd3;
  localparam logic [MODE_W-1:0] MODE_JITTER      = 3'd4;
  localparam logic [MODE_W-1:0] MODE_TILE_FOLD   = 3'd5;

  localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 12'd320;
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = 12'd240;

endpackage

// ===== hdl/psr_if.sv =====
// Valid/ready channel interfaces for the pixel source remap block.
// Depends on psr_pkg for the field widths.
`timescale 1ns / 1ps

interface psr_in_if;
  logic                        valid;
  logic                        ready;
  logic [psr_pkg::COORD_W-1:0] pix_x;
  logic [psr_pkg::COORD_W-1:0] pix_y;
  logic [psr_pkg::JIT_W-1:0]   jitter_x;
  logic [psr_pkg::JIT_W-1:0]   jitter_y;

  modport source (output valid, pix_x, pix_y, jitter_x, jitter_y, input ready);
  modport sink   (input valid, pix_x, pix_y, jitter_x, jitter_y, output ready);
endinterface

interface psr_out_if;
  logic                        valid;
  logic                        ready;
  logic [psr_pkg::COORD_W-1:0] src_x;
  logic [psr_pkg::COORD_W-1:0] src_y;
  logic [psr_pkg::INDEX_W-1:0] src_index;

  modport source (output valid, src_x, src_y, src_index, input ready);
  modport sink   (input valid, src_x, src_y, src_index, output ready);
endinterface

// ===== hdl/psr_cfg_regs.sv =====
// Configuration registers of the pixel source remap block. Frame sizes are
// stored already limited to 1..MAX_DIM. Depends on psr_pkg.
`timescale 1ns / 1ps

module psr_cfg_regs #(
  parameter int MAX_DIM = psr_pkg::MAX_DIM_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [psr_pkg::CFG_ADDR_W-1:0] cfg_index,
  input  logic [psr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output logic [psr_pkg::MODE_W-1:0]     mode,
  output logic [$clog2(MAX_DIM+1)-1:0]   frame_w,
  output logic [$clog2(MAX_DIM+1)-1:0]   frame_h
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int EXT_W = (DIM_W > psr_pkg::CFG_DATA_W) ? DIM_W : psr_pkg::CFG_DATA_W;

  // A size of zero is taken as one and anything above MAX_DIM as MAX_DIM.
  function automatic logic [DIM_W-1:0] dim_of(input logic [psr_pkg::CFG_DATA_W-1:0] v);
    logic [EXT_W-1:0] ext;
    begin
      ext = EXT_W'(v);
      if (v == '0) begin
        dim_of = DIM_W'(1);
      end else if (ext > EXT_W'(MAX_DIM)) begin
        dim_of = DIM_W'(MAX_DIM);
      end else begin
        dim_of = DIM_W'(ext);
      end
    end
  endfunction

  localparam logic [DIM_W-1:0] WIDTH_RST  = dim_of(psr_pkg::WIDTH_RESET);
  localparam logic [DIM_W-1:0] HEIGHT_RST = dim_of(psr_pkg::HEIGHT_RESET);

  logic [psr_pkg::MODE_W-1:0] mode_r;
  logic [DIM_W-1:0]           width_r;
  logic [DIM_W-1:0]           height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= psr_pkg::MODE_IDENTITY;
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        psr_pkg::REG_REMAP_MODE:   mode_r   <= cfg_wdata[psr_pkg::MODE_W-1:0];
        psr_pkg::REG_FRAME_WIDTH:  width_r  <= dim_of(cfg_wdata);
        psr_pkg::REG_FRAME_HEIGHT: height_r <= dim_of(cfg_wdata);
        default: ;
      endcase
    end
  end

  assign mode    = mode_r;
  assign frame_w = width_r;
  assign frame_h = height_r;

endmodule

// ===== hdl/psr_remap.sv =====
// Input register and coordinate remap stage of the pixel source remap block.
// Produces the clamped source column and row. Depends on psr_pkg and psr_in_if.
`timescale 1ns / 1ps

module psr_remap #(
  parameter int MAX_DIM = psr_pkg::MAX_DIM_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  psr_in_if.sink                       in_ch,
  input  logic [psr_pkg::MODE_W-1:0]   mode,
  input  logic [$clog2(MAX_DIM+1)-1:0] frame_w,
  input  logic [$clog2(MAX_DIM+1)-1:0] frame_h,
  output logic                         rm_valid,
  input  logic                         rm_ready,
  output logic [$clog2(MAX_DIM+1)-1:0] sx,
  output logic [$clog2(MAX_DIM+1)-1:0] sy
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int CMP_W = (DIM_W > psr_pkg::COORD_W) ? DIM_W : psr_pkg::COORD_W;
  localparam int SW    = DIM_W + 2;

  // Saturate the coordinate into the frame, then apply the per-axis mapping.
  function automatic logic [DIM_W-1:0] map_axis(
    input logic [psr_pkg::COORD_W-1:0] c_in,
    input logic [DIM_W-1:0]            lim,
    input logic [psr_pkg::JIT_W-1:0]   jit,
    input logic [psr_pkg::MODE_W-1:0]  md,
    input logic                        rev
  );
    logic [DIM_W-1:0]     lim_m1;
    logic [DIM_W-1:0]     c;
    logic [CMP_W-1:0]     c_ext;
    logic signed [SW-1:0] cs;
    logic signed [SW-1:0] ls;
    logic signed [SW-1:0] d;
    logic signed [SW-1:0] s;
    begin
      lim_m1 = lim - DIM_W'(1);
      c_ext  = CMP_W'(c_in);
      c      = (c_ext > CMP_W'(lim_m1)) ? lim_m1 : DIM_W'(c_ext);
      cs     = $signed(SW'(c));
      ls     = $signed(SW'(lim_m1));
      d      = $signed(SW'(c[psr_pkg::TILE_LOG2-1:0])) -
               $signed(SW'(psr_pkg::TILE_SIZE / 2));
      case (md)
        psr_pkg::MODE_JITTER: begin
          s = cs + $signed(SW'(jit)) - $signed(SW'(psr_pkg::JIT_BIAS));
        end
        psr_pkg::MODE_TILE_FOLD: begin
          // Odd tiles subtract, even tiles add, the offset of the coordinate from its tile centre.
          s = c[psr_pkg::TILE_LOG2] ? (cs - d) : (cs + d);
        end
        default: begin
          s = rev ? (ls - cs) : cs;
        end
      endcase
      if (s[SW-1]) begin
        map_axis = '0;
      end else if (s > ls) begin
        map_axis = lim_m1;
      end else begin
        map_axis = DIM_W'(s);
      end
    end
  endfunction

  logic                          a_v_r;
  logic [psr_pkg::COORD_W-1:0]   ax_r;
  logic [psr_pkg::COORD_W-1:0]   ay_r;
  logic [psr_pkg::JIT_W-1:0]     ajx_r;
  logic [psr_pkg::JIT_W-1:0]     ajy_r;
  logic                          b_v_r;
  logic [DIM_W-1:0]              sx_r;
  logic [DIM_W-1:0]              sy_r;
  logic [DIM_W-1:0]              sx_nxt;
  logic [DIM_W-1:0]              sy_nxt;
  logic                          rev_x;
  logic                          rev_y;
  logic                          a_ready;
  logic                          b_ready;

  assign b_ready     = !b_v_r || rm_ready;
  assign a_ready     = !a_v_r || b_ready;
  assign in_ch.ready = a_ready;

  assign rev_x = (mode == psr_pkg::MODE_MIRROR_X) || (mode == psr_pkg::MODE_MIRROR_FLIP);
  assign rev_y = (mode == psr_pkg::MODE_FLIP_Y) || (mode == psr_pkg::MODE_MIRROR_FLIP);

  always_comb begin
    sx_nxt = map_axis(ax_r, frame_w, ajx_r, mode, rev_x);
    sy_nxt = map_axis(ay_r, frame_h, ajy_r, mode, rev_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
    end else begin
      if (a_ready) begin
        a_v_r <= in_ch.valid;
      end
      if (b_ready) begin
        b_v_r <= a_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && a_ready) begin
      ax_r  <= in_ch.pix_x;
      ay_r  <= in_ch.pix_y;
      ajx_r <= in_ch.jitter_x;
      ajy_r <= in_ch.jitter_y;
    end
    if (a_v_r && b_ready) begin
      sx_r <= sx_nxt;
      sy_r <= sy_nxt;
    end
  end

  assign rm_valid = b_v_r;
  assign sx       = sx_r;
  assign sy       = sy_r;

endmodule

// ===== hdl/psr_index.sv =====
// Linear address stage and output register of the pixel source remap block.
// Depends on psr_pkg, psr_out_if and the assertion macro header.
`timescale 1ns / 1ps
`include "pixel_source_remap_assert.svh"

module psr_index #(
  parameter int MAX_DIM = psr_pkg::MAX_DIM_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         s_valid,
  output logic                         s_ready,
  input  logic [$clog2(MAX_DIM+1)-1:0] sx,
  input  logic [$clog2(MAX_DIM+1)-1:0] sy,
  input  logic [$clog2(MAX_DIM+1)-1:0] frame_w,
  psr_out_if.source                    out_ch
);

  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int PROD_W = (2 * DIM_W + 1 > psr_pkg::INDEX_W) ? (2 * DIM_W + 1)
                                                              : psr_pkg::INDEX_W;
  localparam int XE_W   = (DIM_W > psr_pkg::COORD_W) ? DIM_W : psr_pkg::COORD_W;

  logic                        out_v_r;
  logic [psr_pkg::COORD_W-1:0] ox_r;
  logic [psr_pkg::COORD_W-1:0] oy_r;
  logic [psr_pkg::INDEX_W-1:0] oidx_r;
  logic [PROD_W-1:0]           addr;
  logic [XE_W-1:0]             sx_ext;
  logic [XE_W-1:0]             sy_ext;

  assign addr   = PROD_W'(sy) * PROD_W'(frame_w) + PROD_W'(sx);
  assign sx_ext = XE_W'(sx);
  assign sy_ext = XE_W'(sy);

  assign s_ready = !out_v_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s_ready) begin
      out_v_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      ox_r   <= sx_ext[psr_pkg::COORD_W-1:0];
      oy_r   <= sy_ext[psr_pkg::COORD_W-1:0];
      oidx_r <= addr[psr_pkg::INDEX_W-1:0];
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.src_x     = ox_r;
  assign out_ch.src_y     = oy_r;
  assign out_ch.src_index = oidx_r;

  `PSR_ASSERT_ALWAYS(a_rst_clears, clk, !rst_n |=> !out_v_r, "output valid survived reset")
  `PSR_ASSERT(a_xfer_lands, clk, rst_n, s_valid && s_ready |=> out_v_r, "remap result lost")
  `PSR_ASSERT(a_no_phantom, clk, rst_n, out_v_r && out_ch.ready && !s_valid |=> !out_v_r, "result repeated")

endmodule

// ===== hdl/pixel_source_remap.sv =====
// Top level of the pixel source remap block: configuration registers, remap
// stage and address stage. Depends on psr_pkg, psr_if and the stage modules.
`timescale 1ns / 1ps

// Each accepted pixel coordinate yields one transaction carrying the source
// column, row and linear address (row times frame width plus column). A pixel
// passes three register stages (input, remap and output registers); the input
// register loads on the accepting edge. One transaction per clock is
// sustained while the output is ready, and the address multiply occupies the
// last stage on its own. Frame sizes are limited to 1..MAX_DIM when written,
// and coordinates outside the frame are saturated to its last column or row.
// Configuration should be written only while no transaction is in flight.
module pixel_source_remap #(
  parameter int MAX_DIM = psr_pkg::MAX_DIM_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [psr_pkg::CFG_ADDR_W-1:0] cfg_index,
  input  logic [psr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  psr_in_if.sink                         in_chan,
  psr_out_if.source                      out_chan
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);

  logic [psr_pkg::MODE_W-1:0] mode;
  logic [DIM_W-1:0]           frame_w;
  logic [DIM_W-1:0]           frame_h;
  logic                       rm_valid;
  logic                       rm_ready;
  logic [DIM_W-1:0]           sx;
  logic [DIM_W-1:0]           sy;

  psr_cfg_regs #(
    .MAX_DIM (MAX_DIM)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .mode      (mode),
    .frame_w   (frame_w),
    .frame_h   (frame_h)
  );

  psr_remap #(
    .MAX_DIM (MAX_DIM)
  ) u_remap (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_chan),
    .mode     (mode),
    .frame_w  (frame_w),
    .frame_h  (frame_h),
    .rm_valid (rm_valid),
    .rm_ready (rm_ready),
    .sx       (sx),
    .sy       (sy)
  );

  psr_index #(
    .MAX_DIM (MAX_DIM)
  ) u_index (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (rm_valid),
    .s_ready (rm_ready),
    .sx      (sx),
    .sy      (sy),
    .frame_w (frame_w),
    .out_ch  (out_chan)
  );

endmodule
